FILE: hw/rtl/gwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants for the glob wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    localparam logic [7:0] GLOB_STAR = 8'h2A;
    localparam logic [7:0] GLOB_ONE  = 8'h3F;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    // broadcast from the top level to every cell for one accepted beat
    typedef struct packed {
        logic       text_beat;
        logic       append_beat;
        logic       restart_beat;
        logic [7:0] character;
    } cell_cmd_t;

endpackage

FILE: hw/rtl/glob_wildcard_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit
// Streams text against a stored glob pattern with star and question mark.
// ----------------------------------------------------------------------------
// Input beats carry func and character: clear, append pattern byte, text
// byte or end of text. Only end of text returns a result beat on the output
// channel, with matched and too_long.
// Clear, append and text beats are taken one per cycle when input is not
// stalled; each text byte updates all pattern positions in the row of cells
// at once, the star closure riding on one carry chain across the row.
// An end-of-text beat is captured into a result stage, and from there the
// result beat is loaded into the output register. Input stalls while the
// result stage is full, so an end-of-text beat holds the input until its
// result has moved on to the output register.
// While the output holds a stalled result beat, input stalls as well and
// resumes at the edge where the receiver takes that beat.
// At reset the pattern is empty, no overflow is flagged, only position zero
// is active and no result is pending. A pattern beyond MAX_PATTERN bytes
// drops the extra bytes and reports too_long with matched low.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_unit
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] character,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       too_long
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic                   accept;
    func_t                  func_in;
    cell_cmd_t              cmd;
    logic                   end_beat;

    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   tail_reg;

    logic [MAX_PATTERN:0]   active_vec;
    logic [MAX_PATTERN-1:0] star_vec;
    logic [MAX_PATTERN:0]   closed_vec;
    logic [MAX_PATTERN:0]   adv_vec;
    logic [MAX_PATTERN:0]   len_sel;

    logic [MAX_PATTERN:0]   fin_vec_reg;
    logic                   fin_ovf_reg;
    logic                   fin_valid_reg;
    logic                   fin_valid_next;
    logic                   out_valid_reg;
    logic                   matched_reg;
    logic                   too_long_reg;
    logic                   out_load;

    assign accept  = in_valid && !in_stall;
    assign func_in = func_t'(func);

    always_comb
    begin
        cmd.text_beat    = 1'b0;
        cmd.append_beat  = 1'b0;
        cmd.restart_beat = 1'b0;
        cmd.character    = character;
        end_beat         = 1'b0;
        len_next         = len_reg;
        ovf_next         = ovf_reg;
        if (accept)
        begin
            unique case (func_in)
                FUNC_CLEAR:
                begin
                    cmd.restart_beat = 1'b1;
                    len_next         = '0;
                    ovf_next         = 1'b0;
                end
                FUNC_APPEND:
                begin
                    cmd.restart_beat = 1'b1;
                    if (len_reg < LEN_W'(MAX_PATTERN))
                    begin
                        cmd.append_beat = 1'b1;
                        len_next        = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                FUNC_TEXT:
                begin
                    cmd.text_beat = 1'b1;
                end
                FUNC_END:
                begin
                    cmd.restart_beat = 1'b1;
                    end_beat         = 1'b1;
                end
                default:
                begin
                    cmd.restart_beat = 1'b0;
                end
            endcase
        end
    end

    // row of position cells, advance bits ripple to the right neighbour
    assign adv_vec[0] = 1'b0;

    for (genvar p = 0; p < MAX_PATTERN; p++)
    begin : g_cell
        gwm_cell #(
            .IDX   (p),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .len     (len_reg),
            .closed  (closed_vec[p]),
            .adv_in  (adv_vec[p]),
            .adv_out (adv_vec[p+1]),
            .active  (active_vec[p]),
            .star    (star_vec[p])
        );
    end

    for (genvar p = 0; p <= MAX_PATTERN; p++)
    begin : g_sel
        assign len_sel[p] = len_reg == LEN_W'(p);
    end

    assign active_vec[MAX_PATTERN] = tail_reg;

    gwm_closure #(
        .N (MAX_PATTERN)
    ) u_closure (
        .active (active_vec),
        .star   (star_vec),
        .closed (closed_vec)
    );

    assign out_load       = fin_valid_reg && (!out_valid_reg || !out_stall);
    assign fin_valid_next = (fin_valid_reg && !out_load) || end_beat;
    assign in_stall       = fin_valid_reg || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            tail_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            fin_valid_reg <= fin_valid_next;
            // last position only fills from its left neighbour
            if (cmd.restart_beat)
            begin
                tail_reg <= 1'b0;
            end
            else if (cmd.text_beat)
            begin
                tail_reg <= adv_vec[MAX_PATTERN];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_beat)
        begin
            fin_vec_reg <= closed_vec & len_sel;
            fin_ovf_reg <= ovf_reg;
        end
        if (out_load)
        begin
            matched_reg  <= (|fin_vec_reg) && !fin_ovf_reg;
            too_long_reg <= fin_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign too_long  = too_long_reg;

endmodule

FILE: hw/rtl/gwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: holds its pattern byte and active bit, and hands the
// advance bit to the next position on every text beat.
// ----------------------------------------------------------------------------
module gwm_cell
    import gwm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [LEN_W-1:0] len,
    input  logic             closed,
    input  logic             adv_in,
    output logic             adv_out,
    output logic             active,
    output logic             star
);

    logic [7:0] byte_reg;
    logic       active_reg;
    logic       active_next;
    logic       in_use;
    logic       is_one;
    logic       is_match;

    assign in_use   = LEN_W'(IDX) < len;
    assign star     = in_use && (byte_reg == GLOB_STAR);
    assign is_one   = byte_reg == GLOB_ONE;
    assign is_match = byte_reg == cmd.character;
    assign adv_out  = closed && in_use && !star && (is_one || is_match);
    assign active   = active_reg;

    always_comb
    begin
        active_next = active_reg;
        if (cmd.restart_beat)
        begin
            active_next = (IDX == 0);
        end
        else if (cmd.text_beat)
        begin
            // a star keeps itself, anything else arrives from the left
            active_next = (closed && star) || adv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= (IDX == 0);
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append_beat && (len == LEN_W'(IDX)))
        begin
            byte_reg <= cmd.character;
        end
    end

endmodule

FILE: hw/rtl/gwm_closure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_closure
// Star closure over the active set: an active star also activates the next
// position, rippled through runs of stars with one carry chain.
// ----------------------------------------------------------------------------
module gwm_closure
#(
    parameter int N = 64
)
(
    input  logic [N:0]   active,
    input  logic [N-1:0] star,
    output logic [N:0]   closed
);

    logic [N:0] gen;
    logic [N:0] prop;
    logic [N:0] sum;
    logic [N:0] carry_in;

    // carry into p+1 is star[p] & (active[p] | carry into p)
    assign gen      = {1'b0, active[N-1:0] & star};
    assign prop     = {1'b0, star};
    assign sum      = gen + prop;
    assign carry_in = sum ^ gen ^ prop;
    assign closed   = active | carry_in;

endmodule

FILE: tb/glob_wildcard_matcher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit_tb
// Self-checking bench for the streaming glob matcher.
// ----------------------------------------------------------------------------
// A directed table covers the empty pattern, byte extremes, star and question
// mark, dead texts, restart on append, a full pattern and overflow. Random
// sequences then load patterns and stream texts built from them, some of
// them mutated, with a little noise mixed in. Each end-of-text result is checked
// against a typed row's verdict or a predictor that tracks active pattern positions.
// Both channels idle at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_unit_tb;
    import gwm_pkg::*;

    localparam int PAT_CAP      = MAX_PATTERN_DEF;
    localparam int RAND_ITEMS   = 700;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOW_LIMIT   = 10;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_X = 8'h78;

    localparam logic [PAT_CAP:0] LIVE_START = {{PAT_CAP{1'b0}}, 1'b1};

    typedef struct packed {
        logic matched;
        logic too_long;
    } verdict_t;

    localparam verdict_t V_NONE = '{matched: 1'b0, too_long: 1'b0};
    localparam verdict_t V_HIT  = '{matched: 1'b1, too_long: 1'b0};
    localparam verdict_t V_MISS = '{matched: 1'b0, too_long: 1'b0};
    localparam verdict_t V_LONG = '{matched: 1'b0, too_long: 1'b1};

    // typed rows carry their own verdict, the rest go to the predictor
    typedef struct packed {
        func_t      f;
        logic [7:0] c;
        logic [7:0] reps;
        logic       typed;
        verdict_t   v;
    } step_row_t;

    localparam int N_ROWS = 31;
    localparam step_row_t DIR_ROWS [N_ROWS] = '{
        '{FUNC_END,    8'h00,     8'd1,  1'b1, V_HIT},   // empty pattern, empty text
        '{FUNC_TEXT,   8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'hFF,     8'd1,  1'b1, V_MISS},  // empty pattern, some text
        '{FUNC_APPEND, GLOB_STAR, 8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_TEXT,   8'hFF,     8'd1,  1'b0, V_NONE},
        '{FUNC_TEXT,   8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'hFF,     8'd1,  1'b0, V_NONE},
        '{FUNC_CLEAR,  8'hFF,     8'd1,  1'b0, V_NONE},
        '{FUNC_APPEND, CH_A,      8'd1,  1'b0, V_NONE},
        '{FUNC_APPEND, GLOB_ONE,  8'd1,  1'b0, V_NONE},
        '{FUNC_APPEND, 8'hFF,     8'd1,  1'b0, V_NONE},
        '{FUNC_TEXT,   CH_A,      8'd1,  1'b0, V_NONE},
        '{FUNC_TEXT,   8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_TEXT,   8'hFF,     8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_TEXT,   CH_B,      8'd1,  1'b0, V_NONE},  // kills every position
        '{FUNC_TEXT,   CH_A,      8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_TEXT,   CH_A,      8'd1,  1'b0, V_NONE},
        '{FUNC_APPEND, 8'h00,     8'd1,  1'b0, V_NONE},  // append mid-text restarts
        '{FUNC_TEXT,   GLOB_STAR, 8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_CLEAR,  8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_APPEND, GLOB_STAR, 8'd64, 1'b0, V_NONE},  // pattern exactly full
        '{FUNC_END,    8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_APPEND, CH_X,      8'd2,  1'b0, V_NONE},  // past capacity
        '{FUNC_TEXT,   CH_X,      8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'h00,     8'd1,  1'b1, V_LONG},
        '{FUNC_CLEAR,  8'h00,     8'd1,  1'b0, V_NONE},
        '{FUNC_END,    8'hFF,     8'd1,  1'b1, V_HIT}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    func_t      func = FUNC_CLEAR;
    logic [7:0] character = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       matched;
    logic       too_long;

    // predictor state
    logic [7:0]       pat_mem [PAT_CAP];
    int               pat_len = 0;
    logic [PAT_CAP:0] live_pos = LIVE_START;
    logic             pat_overflow = 1'b0;

    verdict_t pending_verdicts [$];
    int       cycles = 0;
    int       fails = 0;
    int       n_beats = 0;
    int       n_results = 0;
    int       n_long = 0;
    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;

    glob_wildcard_matcher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .character (character),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .matched   (matched),
        .too_long  (too_long)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_verdicts.size());
            $display("glob_wildcard_matcher_unit_tb NOT OK");
            $finish;
        end
    end

    // a star at an active position also makes the next position active
    function automatic void star_close();
        for (int p = 0; p < pat_len; p++)
        begin
            if (live_pos[p] && pat_mem[p] == GLOB_STAR)
                live_pos[p + 1] = 1'b1;
        end
    endfunction

    function automatic bit glob_step(input func_t f, input logic [7:0] c,
                                     output verdict_t v);
        logic [PAT_CAP:0] nxt;
        nxt = '0;
        v = V_NONE;
        glob_step = 1'b0;
        case (f)
            FUNC_CLEAR:
            begin
                pat_len = 0;
                pat_overflow = 1'b0;
                live_pos = LIVE_START;
            end
            FUNC_APPEND:
            begin
                if (pat_len < PAT_CAP)
                begin
                    pat_mem[pat_len] = c;
                    pat_len++;
                end
                else
                    pat_overflow = 1'b1;
                live_pos = LIVE_START;
            end
            FUNC_TEXT:
            begin
                star_close();
                for (int p = 0; p < pat_len; p++)
                begin
                    if (live_pos[p])
                    begin
                        if (pat_mem[p] == GLOB_STAR)
                            nxt[p] = 1'b1;
                        else if (pat_mem[p] == GLOB_ONE || pat_mem[p] == c)
                            nxt[p + 1] = 1'b1;
                    end
                end
                live_pos = nxt;
            end
            default:
            begin
                star_close();
                v.matched = live_pos[pat_len] && !pat_overflow;
                v.too_long = pat_overflow;
                live_pos = LIVE_START;
                glob_step = 1'b1;
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_sym();
        logic [7:0] alphabet [4];
        alphabet = '{CH_A, CH_B, GLOB_STAR, GLOB_ONE};
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, 3)];
    endfunction

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= SHOW_LIMIT)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic send_beat(input func_t f, input logic [7:0] c, input bit typed,
                             input verdict_t typed_v);
        int       gap;
        verdict_t v;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        character <= c;
        do @(posedge clk); while (in_stall);
        n_beats++;
        if (glob_step(f, c, v))
            pending_verdicts.insert(pending_verdicts.size(), typed ? typed_v : v);
    endtask

    // result side: random stall ahead of each beat, then compare
    initial
    begin : result_side
        int       hold;
        verdict_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            hold = rx_calm ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            n_results++;
            if (pending_verdicts.size() == 0)
                note_fail($sformatf("unexpected result beat matched=%0b too_long=%0b",
                                    matched, too_long));
            else
            begin
                want = pending_verdicts.pop_front();
                if (want.too_long)
                    n_long++;
                if (matched !== want.matched || too_long !== want.too_long)
                    note_fail($sformatf("expected matched=%0b too_long=%0b, got %0b %0b",
                                        want.matched, want.too_long, matched, too_long));
            end
        end
    end

    initial
    begin : stimulus
        int         target;
        int         plen;
        int         r;
        int         k;
        logic [7:0] pat_q [$];
        logic [7:0] txt_q [$];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < N_ROWS; row++)
        begin
            repeat (DIR_ROWS[row].reps)
                send_beat(DIR_ROWS[row].f, DIR_ROWS[row].c, DIR_ROWS[row].typed,
                          DIR_ROWS[row].v);
        end

        target = n_beats + RAND_ITEMS;
        while (n_beats < target)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                // noise: any func, any byte
                repeat ($urandom_range(1, 6))
                    send_beat(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'b0, V_NONE);
                continue;
            end
            if ($urandom_range(0, 9) != 0)
                send_beat(FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'b0, V_NONE);
            r = $urandom_range(0, 99);
            if (r < 70)
                plen = $urandom_range(0, 6);
            else if (r < 90)
                plen = $urandom_range(7, 20);
            else if (r < 97)
                plen = $urandom_range(21, PAT_CAP);
            else
                plen = $urandom_range(PAT_CAP + 1, PAT_CAP + 4);
            pat_q.delete();
            repeat (plen)
            begin
                pat_q.insert(pat_q.size(), pick_sym());
                send_beat(FUNC_APPEND, pat_q[$], 1'b0, V_NONE);
            end
            repeat ($urandom_range(1, 4))
            begin
                txt_q.delete();
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(0, 8)) txt_q.insert(txt_q.size(), pick_sym());
                else
                begin
                    // text that fits the pattern, sometimes bent by one edit
                    for (int i = 0; i < pat_q.size() && i < PAT_CAP; i++)
                    begin
                        if (pat_q[i] == GLOB_STAR)
                            repeat ($urandom_range(0, 3))
                                txt_q.insert(txt_q.size(), pick_sym());
                        else if (pat_q[i] == GLOB_ONE)
                            txt_q.insert(txt_q.size(), 8'($urandom_range(0, 255)));
                        else
                            txt_q.insert(txt_q.size(), pat_q[i]);
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        k = $urandom_range(0, txt_q.size());
                        case ($urandom_range(0, 2))
                            0: txt_q.insert(k, pick_sym());
                            1: if (k < txt_q.size()) txt_q.delete(k);
                            default: if (k < txt_q.size()) txt_q[k] = pick_sym();
                        endcase
                    end
                end
                foreach (txt_q[i])
                    send_beat(FUNC_TEXT, txt_q[i], 1'b0, V_NONE);
                send_beat(FUNC_END, 8'($urandom_range(0, 255)), 1'b0, V_NONE);
            end
        end
        in_valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d input beats, checked %0d results (%0d on overflowed patterns)",
                 n_beats, n_results, n_long);
        $display("mismatches: %0d, cycles: %0d", fails, cycles);
        if (fails == 0)
            $display("glob_wildcard_matcher_unit_tb OK");
        else
            $display("glob_wildcard_matcher_unit_tb NOT OK");
        $finish;
    end

endmodule
